// ===== hw/rtl/calendar_date_analyzer_unit_defines.svh =====
`ifndef CALENDAR_DATE_ANALYZER_UNIT_DEFINES_SVH
`define CALENDAR_DATE_ANALYZER_UNIT_DEFINES_SVH

// same-cycle implication check
`define CDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define CDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cda_pkg.sv =====
`default_nettype none

package cda_pkg;

  localparam int unsigned WeekDays  = 7;
  localparam int unsigned EraShift  = 400;
  localparam logic [3:0]  MonthFeb  = 4'd2;
  localparam logic [3:0]  MonthDec  = 4'd12;
  localparam logic [4:0]  FebLeap   = 5'd29;
  localparam logic [8:0]  YearDays  = 9'd365;

  // floor(n / 25) as n * ceil(2^17 / 25) >> 17, exact for n < 43690
  localparam int unsigned Div25Shift = 17;
  localparam logic [12:0] Div25Mul   = 13'd5243;
  localparam logic [13:0] Div25      = 14'd25;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [8:0] days_left_in_year;
    logic [4:0] days_left_in_month;
    logic [2:0] days_left_in_week;
    logic       business_day;
    logic       weekend;
    logic       end_of_week;
    logic [4:0] month_length;
    logic       leap_year;
    logic [2:0] day_of_week;
    logic       date_valid;
  } result_t;

  function automatic logic [9:0] div25(input logic [13:0] n);
    logic [26:0] p;
    p = 27'(n) * 27'(Div25Mul);
    return p[26:Div25Shift];
  endfunction

  // 2^3 = 1 mod 7, so octal digits fold
  function automatic logic [2:0] mod7(input logic [15:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
       + 6'(v[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    priority if (s2 >= 4'(2 * WeekDays)) begin
      return 3'(s2 - 4'(2 * WeekDays));
    end else if (s2 >= 4'(WeekDays)) begin
      return 3'(s2 - 4'(WeekDays));
    end else begin
      return s2[2:0];
    end
  endfunction

  // (31 * shifted month) / 12, shifted month = m - 2 (+12 for months up to Feb)
  function automatic logic [5:0] month_offset(input logic [3:0] m);
    logic [5:0] r;
    unique case (m)
      4'd0:    r = 6'd25;
      4'd1:    r = 6'd28;
      4'd2:    r = 6'd31;
      4'd3:    r = 6'd2;
      4'd4:    r = 6'd5;
      4'd5:    r = 6'd7;
      4'd6:    r = 6'd10;
      4'd7:    r = 6'd12;
      4'd8:    r = 6'd15;
      4'd9:    r = 6'd18;
      4'd10:   r = 6'd20;
      4'd11:   r = 6'd23;
      4'd12:   r = 6'd25;
      4'd13:   r = 6'd28;
      4'd14:   r = 6'd31;
      default: r = 6'd33;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      MonthFeb:                                   r = leap ? FebLeap : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/calendar_date_analyzer_unit.sv =====
// Calendar date analyzer: facts about one Gregorian date per word.
//
// Input channel (s_*): one date per word, s_tdata = {pad, year, month, day}.
// Output channel (m_*): one result word per input word, same order.
//
// Pipeline: input register -> date logic -> result register.
// Throughput: one date per cycle while m_tready stays high, set by the two
// register stages; both stages advance together whenever the result
// register is empty or taken.
//
// Stall: while m_tready is low the result holds and the input register
// keeps one more date; s_tready then drops until the result is taken.
// s_tready depends combinationally on m_tready.
//
// Reset (rst, synchronous, active high) empties both stages; no item is held
// across reset. Invalid dates give date_valid = 0 and zero month and year day counts.
`default_nettype none

module calendar_date_analyzer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // day[4:0], month[8:5], year[22:9]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // date_valid[0], day_of_week[3:1], leap_year[4],
                                // month_length[9:5], end_of_week[10], weekend[11],
                                // business_day[12], days_left_in_week[15:13],
                                // days_left_in_month[20:16], days_left_in_year[29:21]
);
  import cda_pkg::*;

  `include "calendar_date_analyzer_unit_defines.svh"

  date_t   s_date;
  date_t   date;
  logic    in_valid;
  logic    advance;
  result_t calc_res;
  result_t res;

  assign s_date.day   = s_tdata[4:0];
  assign s_date.month = s_tdata[8:5];
  assign s_date.year  = s_tdata[22:9];

  cda_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_date   (s_date),
    .advance  (advance),
    .valid    (in_valid),
    .date     (date)
  );

  cda_date_calc u_calc (
    .date (date),
    .res  (calc_res)
  );

  cda_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (advance),
    .res_in   (calc_res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {2'b00, res.days_left_in_year, res.days_left_in_month,
                    res.days_left_in_week, res.business_day, res.weekend,
                    res.end_of_week, res.month_length, res.leap_year,
                    res.day_of_week, res.date_valid};

  `CDA_ASSERT_NEXT(a_accept_fills, clk, rst, s_tvalid && s_tready, in_valid,
                   "accepted date not held in input register")
  `CDA_ASSERT_NEXT(a_stall_holds, clk, rst, in_valid && !advance,
                   in_valid && $stable(date), "stalled date lost or changed")
  `CDA_ASSERT_NOW(a_invalid_zero, clk, rst, m_tvalid && !res.date_valid,
                  (res.days_left_in_month == 5'd0) && (res.days_left_in_year == 9'd0),
                  "invalid date with nonzero day counts")
  `CDA_ASSERT_NOW(a_week_flags, clk, rst, m_tvalid,
                  (res.business_day != res.weekend) && (!res.end_of_week || res.weekend),
                  "week flags inconsistent")

endmodule

`default_nettype wire

// ===== hw/rtl/cda_in_stage.sv =====
`default_nettype none

module cda_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  cda_pkg::date_t s_date,
  input  logic           advance,
  output logic           valid,
  output cda_pkg::date_t date
);
  import cda_pkg::*;

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      date <= s_date;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cda_date_calc.sv =====
`default_nettype none

module cda_date_calc (
  input  cda_pkg::date_t   date,
  output cda_pkg::result_t res
);
  import cda_pkg::*;

  logic        shift;
  logic [14:0] yy;
  logic [12:0] q4;
  logic [9:0]  q100;
  logic [7:0]  q400;
  logic [15:0] wsum;
  logic [2:0]  dow;
  logic [9:0]  q25y;
  logic [13:0] m25;
  logic        div25_y;
  logic        div4_y;
  logic        leap;
  logic [4:0]  mlen;
  logic        valid;
  logic [8:0]  ylen;
  logic [8:0]  doy;
  logic        wkend;

  // weekday: months up to Feb belong to the year before; +400 years keeps it >= 0
  assign shift = (date.month <= MonthFeb);
  assign yy    = 15'(date.year) + 15'(EraShift) - 15'(shift);
  assign q4    = yy[14:2];
  assign q100  = div25({1'b0, q4});
  assign q400  = q100[9:2];
  assign wsum  = 16'(date.day) + 16'(yy) + 16'(q4) + 16'(q400)
               + 16'(month_offset(date.month)) - 16'(q100);
  assign dow   = mod7(wsum);
  assign wkend = (dow == 3'(WeekDays - 2)) || (dow == 3'(WeekDays - 1));

  // leap year: y % 100 == 0 is y % 4 == 0 and y % 25 == 0; 400 likewise with 16
  assign q25y    = div25(date.year);
  assign m25     = 14'(q25y) * Div25;
  assign div25_y = (m25 == date.year);
  assign div4_y  = (date.year[1:0] == 2'd0);
  assign leap    = (div4_y && !div25_y) || ((date.year[3:0] == 4'd0) && div25_y);

  assign mlen  = month_length(date.month, leap);
  assign valid = (mlen != 5'd0) && (date.day != 5'd0) && (date.day <= mlen);
  assign ylen  = YearDays + 9'(leap);
  assign doy   = days_before(date.month) + 9'(date.day)
               + 9'(leap && (date.month > MonthFeb) && (date.month <= MonthDec));

  always_comb begin
    res.date_valid         = valid;
    res.day_of_week        = dow;
    res.leap_year          = leap;
    res.month_length       = mlen;
    res.end_of_week        = (dow == 3'(WeekDays - 1));
    res.weekend            = wkend;
    res.business_day       = !wkend;
    res.days_left_in_week  = 3'(WeekDays - 1) - dow;
    res.days_left_in_month = valid ? (mlen - date.day + 5'd1) : 5'd0;
    res.days_left_in_year  = valid ? (ylen - doy + 9'd1) : 9'd0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cda_out_stage.sv =====
`default_nettype none

module cda_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cda_pkg::result_t res_in,
  output logic             m_tvalid,
  input  logic             m_tready,
  output cda_pkg::result_t res
);
  import cda_pkg::*;

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
    if (in_valid && in_ready) begin
      res <= res_in;
    end
  end

endmodule

`default_nettype wire
